// ===== design/rgb_to_hsl_fixed_macros.svh =====
// Assertion macros used by the checker file of rgb_to_hsl_fixed.
`ifndef RGB_TO_HSL_FIXED_MACROS_SVH
`define RGB_TO_HSL_FIXED_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RTH_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RTH_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/rth_pkg.sv =====
// Package with types and constants of the RGB to HSL converter.
package rth_pkg;

  localparam int unsigned CH_W   = 8;
  localparam int unsigned HUE_W  = 15;
  localparam int unsigned SAT_W  = 17;
  localparam int unsigned LSUM_W = 9;

  localparam int unsigned IN_TDATA_W  = 24;
  localparam int unsigned OUT_TDATA_W = 48;

  // Restoring divider: quotient bits, divisor bits, dividend bits.
  localparam int unsigned DIV_Q_W   = 17;
  localparam int unsigned DIV_DEN_W = 8;
  localparam int unsigned DIV_N_W   = DIV_Q_W + DIV_DEN_W;

  localparam int unsigned NUM_W = 26;

  localparam logic signed [NUM_W-1:0] HUE_SIXTY  = 26'sd3840;
  localparam logic signed [NUM_W-1:0] HUE_ONE20  = 26'sd7680;
  localparam logic signed [NUM_W-1:0] HUE_TWO40  = 26'sd15360;
  localparam logic signed [NUM_W-1:0] HUE_FULL   = 26'sd23040;

  localparam logic [LSUM_W-1:0] LSUM_HALF = 9'd255;
  localparam logic [LSUM_W-1:0] LSUM_FULL = 9'd510;

  localparam logic [HUE_W-1:0]  HUE_MAX  = 15'd23039;
  localparam logic [SAT_W-1:0]  SAT_ONE  = 17'd65536;

  typedef enum logic [1:0] {
    SEC_RED,
    SEC_GREEN,
    SEC_BLUE
  } sector_t;

endpackage

// ===== design/rth_div_pipe.sv =====
// Pipelined restoring divider, one quotient bit per stage.
module rth_div_pipe (
  input  logic                          clk,
  input  logic [rth_pkg::DIV_Q_W-1:0]   en_i,
  input  logic [rth_pkg::DIV_N_W-1:0]   num_i,
  input  logic [rth_pkg::DIV_DEN_W-1:0] den_i,
  output logic [rth_pkg::DIV_Q_W-1:0]   quot_o
);
  import rth_pkg::*;

  // Each word holds {partial remainder, remaining dividend bits / quotient bits}.
  logic [DIV_N_W-1:0]   w_r   [DIV_Q_W];
  logic [DIV_DEN_W-1:0] den_r [DIV_Q_W];
  logic [DIV_N_W-1:0]   src_w   [DIV_Q_W];
  logic [DIV_DEN_W-1:0] src_den [DIV_Q_W];
  logic [DIV_N_W-1:0]   w_nxt   [DIV_Q_W];

  always_comb begin
    src_w[0]   = num_i;
    src_den[0] = den_i;
    for (int k = 1; k < DIV_Q_W; k++) begin
      src_w[k]   = w_r[k-1];
      src_den[k] = den_r[k-1];
    end
  end

  always_comb begin
    for (int k = 0; k < DIV_Q_W; k++) begin
      logic [DIV_DEN_W:0] trial;
      logic [DIV_DEN_W:0] diff;
      trial = src_w[k][DIV_N_W-1:DIV_Q_W-1];
      diff  = trial - {1'b0, src_den[k]};
      if (trial >= {1'b0, src_den[k]}) begin
        w_nxt[k] = {diff[DIV_DEN_W-1:0], src_w[k][DIV_Q_W-2:0], 1'b1};
      end else begin
        w_nxt[k] = {trial[DIV_DEN_W-1:0], src_w[k][DIV_Q_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < DIV_Q_W; k++) begin
      if (en_i[k]) begin
        w_r[k]   <= w_nxt[k];
        den_r[k] <= src_den[k];
      end
    end
  end

  assign quot_o = w_r[DIV_Q_W-1][DIV_Q_W-1:0];

endmodule

// ===== design/rgb_to_hsl_fixed.sv =====
// RGB to HSL converter for 8-bit pixels, fully pipelined. It accepts one pixel
// in every clock cycle while the output side does not stall. Each pixel passes
// through one input register, one stage that finds the largest and smallest
// channel, one stage that builds the hue and saturation dividends, and two
// 17-stage restoring dividers (one quotient bit per stage) that run side by side
// for hue and saturation. Each stage moves on when it is empty or the stage
// after it moves, so bubbles close up during a stall and no transaction is lost
// or repeated. Grey pixels give hue and saturation of zero.
module rgb_to_hsl_fixed (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [7:0] red, [15:8] green, [23:16] blue
  input  logic [rth_pkg::IN_TDATA_W-1:0]    in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [14:0] hue, [31:15] saturation, [40:32] lightness_sum, [47:41] zero
  output logic [rth_pkg::OUT_TDATA_W-1:0]   out_tdata
);
  import rth_pkg::*;

  localparam int unsigned NSTG = 3 + DIV_Q_W;
  localparam int unsigned LAST = NSTG - 1;

  logic [NSTG-1:0] vld_r;
  logic [NSTG-1:0] rdy;

  // Stage ready chain: a stage may load when it is empty or drains this cycle.
  assign rdy[LAST] = !vld_r[LAST] || out_tready;
  for (genvar i = 0; i < LAST; i++) begin : g_rdy
    assign rdy[i] = !vld_r[i] || rdy[i+1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (rdy[0]) vld_r[0] <= in_tvalid;
      for (int i = 1; i < NSTG; i++) begin
        if (rdy[i]) vld_r[i] <= vld_r[i-1];
      end
    end
  end

  assign in_tready  = rdy[0];
  assign out_tvalid = vld_r[LAST];

  // Stage 0: input register.
  logic [CH_W-1:0] red_r, green_r, blue_r;

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      red_r   <= in_tdata[7:0];
      green_r <= in_tdata[15:8];
      blue_r  <= in_tdata[23:16];
    end
  end

  // Stage 1: extremes, sector and channel difference.
  logic [CH_W-1:0]   hi, lo, t_hi, t_lo;
  logic [CH_W-1:0]   c_nxt, c1_r;
  logic [LSUM_W-1:0] sum_nxt, sum1_r;
  logic signed [CH_W:0] diff_nxt, diff1_r;
  sector_t           sec_nxt, sec1_r;

  always_comb begin
    t_hi    = (red_r > green_r) ? red_r : green_r;
    hi      = (t_hi > blue_r) ? t_hi : blue_r;
    t_lo    = (red_r < green_r) ? red_r : green_r;
    lo      = (t_lo < blue_r) ? t_lo : blue_r;
    c_nxt   = hi - lo;
    sum_nxt = {1'b0, hi} + {1'b0, lo};
    if (hi == red_r) begin
      sec_nxt  = SEC_RED;
      diff_nxt = $signed({1'b0, green_r}) - $signed({1'b0, blue_r});
    end else if (hi == green_r) begin
      sec_nxt  = SEC_GREEN;
      diff_nxt = $signed({1'b0, blue_r}) - $signed({1'b0, red_r});
    end else begin
      sec_nxt  = SEC_BLUE;
      diff_nxt = $signed({1'b0, red_r}) - $signed({1'b0, green_r});
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      c1_r    <= c_nxt;
      sum1_r  <= sum_nxt;
      diff1_r <= diff_nxt;
      sec1_r  <= sec_nxt;
    end
  end

  // Stage 2: dividends and divisors.
  logic signed [NUM_W-1:0] diff_ext, c_ext, num;
  logic [LSUM_W-1:0]       den9;
  logic [DIV_N_W-1:0]      hnum_nxt, hnum2_r, snum_nxt, snum2_r;
  logic [DIV_DEN_W-1:0]    hden_nxt, hden2_r, sden_nxt, sden2_r;

  always_comb begin
    diff_ext = {{(NUM_W-CH_W-1){diff1_r[CH_W]}}, diff1_r};
    c_ext    = $signed({{(NUM_W-CH_W){1'b0}}, c1_r});
    case (sec1_r)
      SEC_RED: begin
        num = diff_ext * HUE_SIXTY;
        if (num < 0) num = num + c_ext * HUE_FULL;
      end
      SEC_GREEN: num = diff_ext * HUE_SIXTY + c_ext * HUE_ONE20;
      SEC_BLUE:  num = diff_ext * HUE_SIXTY + c_ext * HUE_TWO40;
      default:   num = '0;
    endcase
    den9 = (sum1_r > LSUM_HALF) ? (LSUM_FULL - sum1_r) : sum1_r;
    if (c1_r == '0 || num[NUM_W-1]) begin
      hnum_nxt = '0;
    end else begin
      hnum_nxt = {2'b00, num[DIV_N_W-3:0]};
    end
    // Grey pixel: zero dividends over a divisor of one give zero.
    if (c1_r == '0) begin
      snum_nxt = '0;
      hden_nxt = 8'd1;
      sden_nxt = 8'd1;
    end else begin
      snum_nxt = {1'b0, c1_r, 16'h0000};
      hden_nxt = c1_r;
      sden_nxt = den9[DIV_DEN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      hnum2_r <= hnum_nxt;
      hden2_r <= hden_nxt;
      snum2_r <= snum_nxt;
      sden2_r <= sden_nxt;
    end
  end

  // Lightness sum rides alongside the dividers.
  logic [LSUM_W-1:0] lsum_r [2:LAST];

  always_ff @(posedge clk) begin
    if (rdy[2]) lsum_r[2] <= sum1_r;
    for (int i = 3; i < NSTG; i++) begin
      if (rdy[i]) lsum_r[i] <= lsum_r[i-1];
    end
  end

  logic [DIV_Q_W-1:0] hue_q, sat_q;

  rth_div_pipe u_hue_div (
    .clk    (clk),
    .en_i   (rdy[LAST:3]),
    .num_i  (hnum2_r),
    .den_i  (hden2_r),
    .quot_o (hue_q)
  );

  rth_div_pipe u_sat_div (
    .clk    (clk),
    .en_i   (rdy[LAST:3]),
    .num_i  (snum2_r),
    .den_i  (sden2_r),
    .quot_o (sat_q)
  );

  assign out_tdata = {7'b0000000, lsum_r[LAST], sat_q, hue_q[HUE_W-1:0]};

endmodule

// ===== design/rth_checker.sv =====
// Port-level checker for the RGB to HSL converter, bound to the top level.
`include "rgb_to_hsl_fixed_macros.svh"

module rth_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic [rth_pkg::IN_TDATA_W-1:0]  in_tdata,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [rth_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import rth_pkg::*;

  logic [HUE_W-1:0]  hue;
  logic [SAT_W-1:0]  sat;
  logic [LSUM_W-1:0] lsum;

  assign hue  = out_tdata[14:0];
  assign sat  = out_tdata[31:15];
  assign lsum = out_tdata[40:32];

  `RTH_ASSERT_NXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "result changed while stalled")
  `RTH_ASSERT_IMP(a_hue_range, clk, rst_n, out_tvalid, hue <= HUE_MAX, "hue beyond 360 degrees")
  `RTH_ASSERT_IMP(a_sat_range, clk, rst_n, out_tvalid, sat <= SAT_ONE && lsum <= LSUM_FULL, "saturation or lightness out of range")
  `RTH_ASSERT_IMP(a_grey_hue, clk, rst_n, out_tvalid && sat == '0, hue == '0 && out_tdata[47:41] == '0, "grey pixel with nonzero hue")
  `RTH_ASSERT_NXT(a_idle_ready, clk, rst_n, !out_tvalid && !in_tvalid, in_tready || out_tvalid, "stalled with no result pending")

endmodule

bind rgb_to_hsl_fixed rth_checker u_rth_checker (.*);

// ===== tb/sv/tb_rgb_to_hsl_fixed.sv =====
// Self-checking testbench for rgb_to_hsl_fixed: directed and random pixels, scoreboard check.
module tb_rgb_to_hsl_fixed;
  import rth_pkg::*;

  localparam int DEG60     = 3840;
  localparam int DEG360    = 23040;
  localparam int SAT_SHIFT = 16;
  localparam int TAIL_CYC  = 40;
  localparam int PHASE_PIX = 410;

  typedef struct packed {
    logic [HUE_W-1:0]  hue;
    logic [SAT_W-1:0]  sat;
    logic [LSUM_W-1:0] lsum;
  } hsl_t;

  class hsl_scoreboard;
    hsl_t expected_q[$];
    int   mismatches;
    int   checked;
    int   noted;
    int   grey_seen;

    function new();
      mismatches = 0;
      checked    = 0;
      noted      = 0;
      grey_seen  = 0;
    endfunction

    function hsl_t hsl_of(logic [CH_W-1:0] red, logic [CH_W-1:0] green,
                          logic [CH_W-1:0] blue);
      int      ri, gi, bi, hi, lo, c, sum, num, den;
      sector_t sec;
      hsl_t    res;
      ri = red;
      gi = green;
      bi = blue;
      hi = (ri > gi) ? ri : gi;
      hi = (hi > bi) ? hi : bi;
      lo = (ri < gi) ? ri : gi;
      lo = (lo < bi) ? lo : bi;
      c = hi - lo;
      sum = hi + lo;
      res.hue = '0;
      res.sat = '0;
      res.lsum = LSUM_W'(sum);
      if (c != 0) begin
        // ties resolve red first, then green
        if (hi == ri) sec = SEC_RED;
        else if (hi == gi) sec = SEC_GREEN;
        else sec = SEC_BLUE;
        case (sec)
          SEC_RED: begin
            num = DEG60 * (gi - bi);
            if (num < 0) num = num + DEG360 * c;
          end
          SEC_GREEN: num = DEG60 * (bi - ri) + 2 * DEG60 * c;
          default:   num = DEG60 * (ri - gi) + 4 * DEG60 * c;
        endcase
        if (num < 0) num = 0;
        res.hue = HUE_W'(num / c);
        den = (sum > 255) ? (510 - sum) : sum;
        if (den != 0) res.sat = SAT_W'((c << SAT_SHIFT) / den);
      end else begin
        grey_seen++;
      end
      return res;
    endfunction

    function void note_pixel(logic [IN_TDATA_W-1:0] pix);
      noted++;
      expected_q.push_back(hsl_of(pix[7:0], pix[15:8], pix[23:16]));
    endfunction

    function void check_result(logic [OUT_TDATA_W-1:0] word);
      hsl_t exp_r;
      if (expected_q.size() == 0) begin
        $error("result with no pixel pending: %h", word);
        mismatches++;
        return;
      end
      exp_r = expected_q.pop_front();
      checked++;
      if (word[14:0] !== exp_r.hue) begin
        $error("hue: expected %0d, got %0d", exp_r.hue, word[14:0]);
        mismatches++;
      end
      if (word[31:15] !== exp_r.sat) begin
        $error("saturation: expected %0d, got %0d", exp_r.sat, word[31:15]);
        mismatches++;
      end
      if (word[40:32] !== exp_r.lsum) begin
        $error("lightness_sum: expected %0d, got %0d", exp_r.lsum, word[40:32]);
        mismatches++;
      end
      if (word[47:41] !== 7'd0) begin
        $error("padding: expected 0, got %0d", word[47:41]);
        mismatches++;
      end
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  int send_idle_pct = 0;
  int stall_pct = 0;

  hsl_scoreboard sb = new();

  rgb_to_hsl_fixed uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) sb.note_pixel(in_tdata);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      in_tdata  <= IN_TDATA_W'($urandom);
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {b, g, r};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // hold the sender off until every pending pixel has its result
  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
  endtask

  initial begin
    logic [7:0] r, g, b;
    int         mode;
    int         send_pcts[4];
    int         stall_pcts[4];
    send_pcts  = '{0, 60, 0, 12};
    stall_pcts = '{0, 0, 60, 12};

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // extremes, primaries, ties and the red sector wrapping below zero
    send_pixel(8'd0,   8'd0,   8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd128, 8'd128, 8'd128);
    send_pixel(8'd255, 8'd0,   8'd0);
    send_pixel(8'd0,   8'd255, 8'd0);
    send_pixel(8'd0,   8'd0,   8'd255);
    send_pixel(8'd255, 8'd255, 8'd0);
    send_pixel(8'd0,   8'd255, 8'd255);
    send_pixel(8'd255, 8'd0,   8'd255);
    send_pixel(8'd255, 8'd0,   8'd1);
    send_pixel(8'd255, 8'd1,   8'd0);
    send_pixel(8'd200, 8'd50,  8'd100);
    send_pixel(8'd1,   8'd0,   8'd0);
    send_pixel(8'd0,   8'd0,   8'd1);
    send_pixel(8'd255, 8'd254, 8'd254);
    send_pixel(8'd127, 8'd128, 8'd127);
    send_pixel(8'd128, 8'd127, 8'd0);
    send_pixel(8'd0,   8'd128, 8'd255);
    send_pixel(8'd255, 8'd128, 8'd128);
    send_pixel(8'd10,  8'd200, 8'd10);
    send_pixel(8'd100, 8'd100, 8'd200);
    send_pixel(8'd254, 8'd255, 8'd255);
    drain_results();

    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct = send_pcts[phase];
      stall_pct     = stall_pcts[phase];
      for (int i = 0; i < PHASE_PIX; i++) begin
        mode = $urandom_range(9);
        r = 8'($urandom_range(255));
        g = 8'($urandom_range(255));
        b = 8'($urandom_range(255));
        case (mode)
          5: begin
            g = r;
            b = r;
          end
          6: g = r;
          7: b = (r > g) ? r : g;
          8: begin
            r = {8{1'($urandom_range(1))}} ^ 8'($urandom_range(1));
            g = {8{1'($urandom_range(1))}} ^ 8'($urandom_range(1));
            b = {8{1'($urandom_range(1))}} ^ 8'($urandom_range(1));
          end
          9: begin
            g = r ^ 8'($urandom_range(3));
            b = r ^ 8'($urandom_range(3));
          end
          default: ;
        endcase
        send_pixel(r, g, b);
      end
      drain_results();
    end

    repeat (TAIL_CYC) @(posedge clk);
    $display("Checked %0d results against %0d accepted pixels (%0d grey),",
             sb.checked, sb.noted, sb.grey_seen);
    $display("through back-to-back, sender-gap, receiver-stall and mixed traffic.");
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+design
design/rth_pkg.sv
design/rth_div_pipe.sv
design/rgb_to_hsl_fixed.sv
design/rth_checker.sv
tb/sv/tb_rgb_to_hsl_fixed.sv
